// File: src/tlt_pkg.sv
`timescale 1ns / 1ps
package tlt_pkg;
   localparam int TABLE_DEPTH_DEF = 32;
   localparam int ID_WIDTH_DEF = 32;
   localparam int CFG_WIDTH = 8;
   localparam int CFG_INDEX_WIDTH = 2;
   localparam int CNT_WIDTH = 16;

   localparam logic [2:0] OP_CREATE = 3'd0;
   localparam logic [2:0] OP_ASSOC = 3'd1;
   localparam logic [2:0] OP_MISS = 3'd2;
   localparam logic [2:0] OP_QUERY = 3'd3;
   localparam logic [2:0] OP_LIST = 3'd4;
   localparam logic [2:0] OP_PRUNE = 3'd5;
   localparam logic [2:0] OP_SPARE_LO = 3'd6;
   localparam logic [2:0] OP_SPARE_HI = 3'd7;

   localparam logic [1:0] ST_TENT = 2'd0;
   localparam logic [1:0] ST_CONF = 2'd1;
   localparam logic [1:0] ST_COAST = 2'd2;
   localparam logic [1:0] ST_DEL = 2'd3;

   localparam logic [1:0] ERR_OK = 2'd0;
   localparam logic [1:0] ERR_UNKNOWN = 2'd1;
   localparam logic [1:0] ERR_FULL = 2'd2;
   localparam logic [1:0] ERR_CONFIG = 2'd3;

   localparam logic [1:0] CSR_CONFIRM = 2'd0;
   localparam logic [1:0] CSR_COAST = 2'd1;
   localparam logic [1:0] CSR_TENT_DROP = 2'd2;
   localparam logic [1:0] CSR_CONF_DROP = 2'd3;

   typedef struct packed {
      logic [2:0] operation;
      logic [31:0] target_id;
   } req_type;

   typedef struct packed {
      logic [31:0] result_id;
      logic [1:0] track_status;
      logic was_confirmed;
      logic [15:0] hit_run;
      logic [15:0] miss_run;
      logic [15:0] hit_total;
      logic [15:0] age;
      logic [1:0] error_code;
      logic last;
   } rsp_type;
endpackage

// File: src/tlt_req_if.sv
`timescale 1ns / 1ps
interface tlt_req_if;
   logic valid;
   logic ready;
   tlt_pkg::req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// File: src/tlt_rsp_if.sv
`timescale 1ns / 1ps
interface tlt_rsp_if;
   logic valid;
   logic ready;
   tlt_pkg::rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// File: src/track_lifecycle_table_top.sv
`timescale 1ns / 1ps
// Create, and any operation on an empty table, has its result registered in the cycle after the transfer.
// Associate, miss and query read the entries in order until one matches the id;
// an unknown id is reported after the last entry; associate and miss then write back.
// List emits each live entry, waiting on output stalls; prune compacts the kept entries.
// One operation is in flight; the next is taken once its last result has transferred.
// Synchronous active-high reset clears the count, sets the next id to 1 and restores thresholds.
module track_lifecycle_table_top #(
   parameter int TABLE_DEPTH = tlt_pkg::TABLE_DEPTH_DEF,
   parameter int ID_WIDTH = tlt_pkg::ID_WIDTH_DEF
) (
   input logic clock,
   input logic reset,
   tlt_req_if.sink req,
   tlt_rsp_if.source rsp,
   input logic csr_write_enable,
   input logic [tlt_pkg::CFG_INDEX_WIDTH-1:0] csr_index,
   input logic [tlt_pkg::CFG_WIDTH-1:0] csr_write_data
);
   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   typedef struct packed {
      logic [ID_WIDTH-1:0] id;
      logic [1:0] status;
      logic conf;
      logic [15:0] hit_run;
      logic [15:0] miss_run;
      logic [15:0] hit_total;
      logic [15:0] age;
   } entry_type;

   typedef enum logic [2:0] {
      S_IDLE, S_READ, S_CHECK, S_EMIT, S_WRITE
   } state_type;

   entry_type mem [TABLE_DEPTH];
   entry_type rd_ff;
   logic [7:0] cfg_confirm_ff, cfg_coast_ff, cfg_tdrop_ff, cfg_cdrop_ff;
   logic [CW-1:0] count_ff, scan_ff, wptr_ff;
   logic [ID_WIDTH-1:0] next_id_ff;
   state_type state_ff;
   logic [2:0] op_ff;
   logic [31:0] req_id_ff;
   logic rsp_valid_ff;
   tlt_pkg::rsp_type rsp_ff;
   logic found_ff;
   logic wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   entry_type wr_data, upd;
   logic cfg_ok;

   assign cfg_ok = cfg_confirm_ff != 8'd0 && cfg_coast_ff != 8'd0 && cfg_tdrop_ff != 8'd0
      && cfg_cdrop_ff >= cfg_coast_ff;
   assign req.ready = state_ff == S_IDLE && !rsp_valid_ff;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.payload = rsp_ff;
   assign rd_addr = scan_ff[AW-1:0];

   function automatic logic [15:0] sat_inc(input logic [15:0] v);
      return (v == 16'hFFFF) ? v : v + 16'd1;
   endfunction

   function automatic tlt_pkg::rsp_type plain(input logic [31:0] rid, input logic [1:0] st,
                                               input logic [1:0] err);
      tlt_pkg::rsp_type r;
      r = '0;
      r.result_id = rid;
      r.track_status = st;
      r.error_code = err;
      r.last = 1'b1;
      return r;
   endfunction

   function automatic tlt_pkg::rsp_type from_entry(input entry_type e, input logic lst);
      tlt_pkg::rsp_type r;
      r.result_id = 32'(e.id);
      r.track_status = e.status;
      r.was_confirmed = e.conf;
      r.hit_run = e.hit_run;
      r.miss_run = e.miss_run;
      r.hit_total = e.hit_total;
      r.age = e.age;
      r.error_code = tlt_pkg::ERR_OK;
      r.last = lst;
      return r;
   endfunction

   always_comb begin
      upd = rd_ff;
      if (op_ff == tlt_pkg::OP_ASSOC) begin
         upd.age = sat_inc(rd_ff.age);
         upd.hit_total = sat_inc(rd_ff.hit_total);
         upd.hit_run = sat_inc(rd_ff.hit_run);
         upd.miss_run = '0;
         if (rd_ff.conf || upd.hit_run >= {8'd0, cfg_confirm_ff}) begin
            upd.status = tlt_pkg::ST_CONF;
            upd.conf = 1'b1;
         end else begin
            upd.status = tlt_pkg::ST_TENT;
         end
      end else if (op_ff == tlt_pkg::OP_MISS) begin
         upd.age = sat_inc(rd_ff.age);
         upd.miss_run = sat_inc(rd_ff.miss_run);
         upd.hit_run = '0;
         if (!rd_ff.conf) begin
            if (upd.miss_run >= {8'd0, cfg_tdrop_ff}) upd.status = tlt_pkg::ST_DEL;
         end else if (upd.miss_run >= {8'd0, cfg_cdrop_ff}) begin
            upd.status = tlt_pkg::ST_DEL;
         end else if (upd.miss_run >= {8'd0, cfg_coast_ff}) begin
            upd.status = tlt_pkg::ST_COAST;
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_ff <= mem[rd_addr];
      if (wr_en) mem[wr_addr] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_confirm_ff <= 8'd3;
         cfg_coast_ff <= 8'd2;
         cfg_tdrop_ff <= 8'd2;
         cfg_cdrop_ff <= 8'd5;
      end else if (csr_write_enable) begin
         case (csr_index)
            tlt_pkg::CSR_CONFIRM: cfg_confirm_ff <= csr_write_data;
            tlt_pkg::CSR_COAST: cfg_coast_ff <= csr_write_data;
            tlt_pkg::CSR_TENT_DROP: cfg_tdrop_ff <= csr_write_data;
            tlt_pkg::CSR_CONF_DROP: cfg_cdrop_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      wr_en = 1'b0;
      wr_addr = '0;
      wr_data = upd;
      if (state_ff == S_IDLE && req.valid && req.ready && cfg_ok
          && req.payload.operation == tlt_pkg::OP_CREATE
          && count_ff != CW'(TABLE_DEPTH)) begin
         wr_en = 1'b1;
         wr_addr = count_ff[AW-1:0];
         wr_data.id = next_id_ff;
         wr_data.status = (cfg_confirm_ff == 8'd1) ? tlt_pkg::ST_CONF : tlt_pkg::ST_TENT;
         wr_data.conf = cfg_confirm_ff == 8'd1;
         wr_data.hit_run = 16'd1;
         wr_data.miss_run = '0;
         wr_data.hit_total = 16'd1;
         wr_data.age = 16'd1;
      end else if (state_ff == S_WRITE) begin
         wr_en = 1'b1;
         wr_addr = (op_ff == tlt_pkg::OP_PRUNE) ? wptr_ff[AW-1:0] : scan_ff[AW-1:0];
         wr_data = upd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff <= '0;
         next_id_ff <= ID_WIDTH'(1);
         scan_ff <= '0;
         wptr_ff <= '0;
         found_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp.ready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (req.valid && req.ready && req.payload.operation <= tlt_pkg::OP_PRUNE) begin
                  op_ff <= req.payload.operation;
                  req_id_ff <= req.payload.target_id;
                  scan_ff <= '0;
                  wptr_ff <= '0;
                  found_ff <= 1'b0;
                  if (!cfg_ok) begin
                     rsp_ff <= plain('0, tlt_pkg::ST_TENT, tlt_pkg::ERR_CONFIG);
                     rsp_valid_ff <= 1'b1;
                  end else if (req.payload.operation == tlt_pkg::OP_CREATE) begin
                     if (count_ff == CW'(TABLE_DEPTH)) begin
                        rsp_ff <= plain('0, tlt_pkg::ST_TENT, tlt_pkg::ERR_FULL);
                     end else begin
                        rsp_ff <= from_entry(wr_data, 1'b1);
                        count_ff <= count_ff + CW'(1);
                        next_id_ff <= next_id_ff + ID_WIDTH'(1);
                     end
                     rsp_valid_ff <= 1'b1;
                  end else if (count_ff == '0) begin
                     if (req.payload.operation == tlt_pkg::OP_LIST)
                        rsp_ff <= plain('0, tlt_pkg::ST_DEL, tlt_pkg::ERR_OK);
                     else if (req.payload.operation == tlt_pkg::OP_PRUNE)
                        rsp_ff <= plain('0, tlt_pkg::ST_TENT, tlt_pkg::ERR_OK);
                     else
                        rsp_ff <= plain(req.payload.target_id, tlt_pkg::ST_TENT,
                                        tlt_pkg::ERR_UNKNOWN);
                     rsp_valid_ff <= 1'b1;
                  end else begin
                     state_ff <= S_READ;
                  end
               end
            end
            S_READ: state_ff <= S_CHECK;
            S_CHECK: begin
               case (op_ff)
                  tlt_pkg::OP_ASSOC, tlt_pkg::OP_MISS, tlt_pkg::OP_QUERY: begin
                     if (rd_ff.id == ID_WIDTH'(req_id_ff) && (ID_WIDTH >= 32
                         || req_id_ff >> ID_WIDTH == 32'd0)) begin
                        rsp_ff <= from_entry(upd, 1'b1);
                        rsp_valid_ff <= 1'b1;
                        state_ff <= (op_ff == tlt_pkg::OP_QUERY) ? S_IDLE : S_WRITE;
                     end else if (scan_ff + CW'(1) == count_ff) begin
                        rsp_ff <= plain(req_id_ff, tlt_pkg::ST_TENT, tlt_pkg::ERR_UNKNOWN);
                        rsp_valid_ff <= 1'b1;
                        state_ff <= S_IDLE;
                     end else begin
                        scan_ff <= scan_ff + CW'(1);
                        state_ff <= S_READ;
                     end
                  end
                  tlt_pkg::OP_LIST: begin
                     if (rd_ff.status != tlt_pkg::ST_DEL) begin
                        if (found_ff) begin
                           rsp_ff.last <= 1'b0;
                           rsp_valid_ff <= 1'b1;
                        end
                        found_ff <= 1'b1;
                        state_ff <= S_EMIT;
                        wptr_ff <= scan_ff;
                     end else if (scan_ff + CW'(1) == count_ff) begin
                        if (found_ff) rsp_ff.last <= 1'b1;
                        else rsp_ff <= plain('0, tlt_pkg::ST_DEL, tlt_pkg::ERR_OK);
                        rsp_valid_ff <= 1'b1;
                        state_ff <= S_IDLE;
                     end else begin
                        scan_ff <= scan_ff + CW'(1);
                        state_ff <= S_READ;
                     end
                  end
                  default: begin
                     if (rd_ff.status != tlt_pkg::ST_DEL) begin
                        state_ff <= S_WRITE;
                     end else if (scan_ff + CW'(1) == count_ff) begin
                        count_ff <= wptr_ff;
                        rsp_ff <= plain(32'(wptr_ff), tlt_pkg::ST_TENT, tlt_pkg::ERR_OK);
                        rsp_valid_ff <= 1'b1;
                        state_ff <= S_IDLE;
                     end else begin
                        scan_ff <= scan_ff + CW'(1);
                        state_ff <= S_READ;
                     end
                  end
               endcase
            end
            S_EMIT: begin
               if (!rsp_valid_ff || rsp.ready) begin
                  rsp_ff <= from_entry(rd_ff, scan_ff + CW'(1) == count_ff);
                  if (scan_ff + CW'(1) == count_ff) begin
                     rsp_valid_ff <= 1'b1;
                     state_ff <= S_IDLE;
                  end else begin
                     scan_ff <= scan_ff + CW'(1);
                     state_ff <= S_READ;
                  end
               end
            end
            S_WRITE: begin
               if (op_ff == tlt_pkg::OP_PRUNE) begin
                  if (scan_ff + CW'(1) == count_ff) begin
                     count_ff <= wptr_ff + CW'(1);
                     rsp_ff <= plain(32'(wptr_ff + CW'(1)), tlt_pkg::ST_TENT,
                                     tlt_pkg::ERR_OK);
                     rsp_valid_ff <= 1'b1;
                     state_ff <= S_IDLE;
                  end else begin
                     wptr_ff <= wptr_ff + CW'(1);
                     scan_ff <= scan_ff + CW'(1);
                     state_ff <= S_READ;
                  end
               end else begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
